@@ sv/lkvc_pkg.sv @@
// Package with the shared types and constants of the LRU key-value cache.
package lkvc_pkg;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_UPDATE = 4'b0100,
    ST_OUT    = 4'b1000
  } state_t;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;
  localparam logic [4:0]  CAPACITY_RESET = 5'd16;

endpackage

@@ sv/lru_key_value_cache_unit.sv @@
// Fully associative key-value cache with least-recently-used replacement.
//
// An operation arrives on the input channel (in_valid, in_stall) as cmd,
// lookup_key and store_value; cmd selects a get or a put. Each transfer
// produces exactly one result on the output channel (out_valid, out_stall):
// hit, read_value, evicted and evicted_key.
// A single key comparator and a single recency comparator sweep the key and
// value memories one entry per cycle behind a registered read.
// The input is stalled from the accepting edge until the result has been
// transferred, so a new operation can be taken in the cycle after it.
// If the receiver stalls, the result stays on the output unchanged.
// Reset empties the cache at once and sets the capacity register to 16.
// The capacity register is written through cfg_wr_en and capacity_in_use;
// the user must write it only while the cache is empty and idle; the block
// does not enforce it. Zero acts as one, values above ENTRIES as ENTRIES.
module lru_key_value_cache_unit #(
  parameter int ENTRIES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [4:0]         capacity_in_use,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               cmd,
  input  logic signed [31:0] lookup_key,
  input  logic signed [31:0] store_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               hit,
  output logic signed [31:0] read_value,
  output logic               evicted,
  output logic signed [31:0] evicted_key
);
  import lkvc_pkg::*;

  localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OW   = $clog2(ENTRIES + 1);
  localparam int CMPW = (OW > 5) ? OW : 5;
  localparam logic [IW-1:0]   LAST_IDX = IW'(ENTRIES - 1);
  localparam logic [CMPW-1:0] ENTRIES_C = CMPW'(ENTRIES);

  state_t state;

  logic [31:0] key_mem [ENTRIES];
  logic [31:0] val_mem [ENTRIES];
  logic [31:0] key_q;
  logic [31:0] val_q;

  logic [ENTRIES-1:0] valid;
  logic [RW-1:0]      rank [ENTRIES];
  logic [OW-1:0]      occupancy;
  logic [4:0]         capacity;

  logic        req_cmd;
  logic [31:0] req_key;
  logic [31:0] req_val;

  logic [IW-1:0] scan_idx;
  logic          issuing;
  logic [IW-1:0] cmp_idx;
  logic          cmp_vld;

  logic          found;
  logic [IW-1:0] hit_idx;
  logic [RW-1:0] hit_rank;
  logic [31:0]   hit_val;
  logic          old_found;
  logic [IW-1:0] old_idx;
  logic [RW-1:0] old_rank;
  logic [31:0]   old_key;
  logic          free_found;
  logic [IW-1:0] free_idx;

  logic [CMPW-1:0] cap_eff;
  logic            do_evict;
  logic            do_insert;
  logic [IW-1:0]   slot;
  logic            mem_we;
  logic [IW-1:0]   mem_waddr;
  logic            key_we;

  always_comb begin
    if (capacity == 5'd0) begin
      cap_eff = CMPW'(1);
    end else if (CMPW'(capacity) > ENTRIES_C) begin
      cap_eff = ENTRIES_C;
    end else begin
      cap_eff = CMPW'(capacity);
    end
    do_evict = (req_cmd == CMD_PUT) && !found && old_found &&
               (CMPW'(occupancy) >= cap_eff);
    if (do_evict) begin
      slot = (free_found && (free_idx < old_idx)) ? free_idx : old_idx;
    end else begin
      slot = free_idx;
    end
    do_insert = (req_cmd == CMD_PUT) && !found && (do_evict || free_found);
    mem_we    = (state == ST_UPDATE) && (req_cmd == CMD_PUT) && (found || do_insert);
    key_we    = (state == ST_UPDATE) && do_insert;
    mem_waddr = found ? hit_idx : slot;
  end

  always_ff @(posedge clk) begin
    key_q <= key_mem[scan_idx];
    val_q <= val_mem[scan_idx];
    if (mem_we) begin
      val_mem[mem_waddr] <= req_val;
    end
    if (key_we) begin
      key_mem[mem_waddr] <= req_key;
    end
  end

  assign in_stall  = (state != ST_IDLE);
  assign out_valid = (state == ST_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      valid     <= '0;
      occupancy <= '0;
      capacity  <= CAPACITY_RESET;
      issuing   <= 1'b0;
      cmp_vld   <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        capacity <= capacity_in_use;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            req_cmd    <= cmd;
            req_key    <= lookup_key;
            req_val    <= store_value;
            scan_idx   <= '0;
            issuing    <= 1'b1;
            cmp_vld    <= 1'b0;
            found      <= 1'b0;
            old_found  <= 1'b0;
            free_found <= 1'b0;
            state      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (issuing) begin
            if (scan_idx == LAST_IDX) begin
              issuing <= 1'b0;
            end else begin
              scan_idx <= scan_idx + 1'b1;
            end
          end
          cmp_vld <= issuing;
          cmp_idx <= scan_idx;
          if (cmp_vld) begin
            if (valid[cmp_idx] && (key_q == req_key) && !found) begin
              found    <= 1'b1;
              hit_idx  <= cmp_idx;
              hit_rank <= rank[cmp_idx];
              hit_val  <= val_q;
            end
            if (valid[cmp_idx] && (!old_found || (rank[cmp_idx] > old_rank))) begin
              old_found <= 1'b1;
              old_idx   <= cmp_idx;
              old_rank  <= rank[cmp_idx];
              old_key   <= key_q;
            end
            if (!valid[cmp_idx] && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= cmp_idx;
            end
            if (cmp_idx == LAST_IDX) begin
              state <= ST_UPDATE;
            end
          end
        end
        ST_UPDATE: begin
          hit         <= found;
          evicted     <= do_evict;
          evicted_key <= do_evict ? old_key : 32'd0;
          if (req_cmd == CMD_GET) begin
            read_value <= found ? hit_val : MISS_VALUE;
          end else begin
            read_value <= 32'd0;
          end
          if (found) begin
            for (int i = 0; i < ENTRIES; i++) begin
              if (IW'(i) == hit_idx) begin
                rank[i] <= '0;
              end else if (valid[i] && (rank[i] < hit_rank)) begin
                rank[i] <= rank[i] + 1'b1;
              end
            end
          end else if (req_cmd == CMD_PUT) begin
            for (int i = 0; i < ENTRIES; i++) begin
              if (do_insert && (IW'(i) == slot)) begin
                valid[i] <= 1'b1;
                rank[i]  <= '0;
              end else if (do_evict && (IW'(i) == old_idx)) begin
                valid[i] <= 1'b0;
                rank[i]  <= '0;
              end else if (do_insert && valid[i]) begin
                rank[i] <= rank[i] + 1'b1;
              end
            end
            if (do_insert && !do_evict) begin
              occupancy <= occupancy + 1'b1;
            end else if (!do_insert && do_evict) begin
              occupancy <= occupancy - 1'b1;
            end
          end
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_stall) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
